FILE: design/lrg_pkg.sv
package lrg_pkg;

    localparam int GRID_WIDTH  = 64;
    localparam int GRID_HEIGHT = 32;

    localparam int XW = 6;
    localparam int YW = 5;
    localparam int ROW_COUNT = 32;

    // Arithmetic width of the Bresenham error term and the axis distances.
    localparam int EW = 10;

    localparam logic ACTION_DRAW  = 1'b0;
    localparam logic ACTION_CLEAR = 1'b1;

    typedef enum logic [1:0] {
        GLYPH_DASH      = 2'd0,
        GLYPH_SLASH     = 2'd1,
        GLYPH_BACKSLASH = 2'd2
    } t_glyph;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_WALK = 2'b10
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic clear;
        logic step;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic done;
    } t_status;

endpackage

FILE: design/lrg_in_if.sv
interface lrg_in_if;
    import lrg_pkg::*;

    logic          valid;
    logic          ready;
    logic          action;
    logic [XW-1:0] x_start;
    logic [YW-1:0] y_start;
    logic [XW-1:0] x_end;
    logic [YW-1:0] y_end;

    modport source (output valid, action, x_start, y_start, x_end, y_end, input ready);
    modport sink   (input valid, action, x_start, y_start, x_end, y_end, output ready);
endinterface

FILE: design/lrg_out_if.sv
interface lrg_out_if;
    import lrg_pkg::*;

    logic          valid;
    logic          ready;
    logic [XW-1:0] point_x;
    logic [YW-1:0] point_y;
    logic [1:0]    glyph;
    logic          write_cell;
    logic          last_point;

    modport source (output valid, point_x, point_y, glyph, write_cell, last_point,
                    input ready);
    modport sink   (input valid, point_x, point_y, glyph, write_cell, last_point,
                    output ready);
endinterface

FILE: design/line_rasterizer_with_glyphs.sv
// The first point of a line is offered in the cycle after the request transaction.
// One point is handed out per cycle while the sink is ready; a line holds the block until
// its last point is taken, and the next request is taken in the cycle after the last point.
// A clear request empties the bitmap and produces no output transaction.
// Reset (synchronous, active low) returns the controller to idle and empties the bitmap.
module line_rasterizer_with_glyphs (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lrg_in_if.sink     i_in,
    lrg_out_if.source  o_out
);
    import lrg_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    // The controller decides when a request is taken and when the walk
    // advances; it never looks at coordinates, only at the action and the done status.
    lrg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_action    (i_in.action),
        .i_out_ready (o_out.ready),
        .i_status    (w_status),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .o_cmd       (w_cmd)
    );

    // The datapath holds the current point, the error term and the
    // occupancy bitmap. The bitmap is only updated when a point transaction
    // completes, so a stalled point keeps a stable write flag.
    lrg_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_x_start    (i_in.x_start),
        .i_y_start    (i_in.y_start),
        .i_x_end      (i_in.x_end),
        .i_y_end      (i_in.y_end),
        .o_status     (w_status),
        .o_point_x    (o_out.point_x),
        .o_point_y    (o_out.point_y),
        .o_glyph      (o_out.glyph),
        .o_write_cell (o_out.write_cell)
    );

    // Every line ends exactly at its end point, so the done status marks
    // the final point.
    assign o_out.last_point = w_status.done;
endmodule

FILE: design/lrg_ctrl.sv
module lrg_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_action,
    input  logic             i_out_ready,
    input  lrg_pkg::t_status i_status,
    output logic             o_in_ready,
    output logic             o_out_valid,
    output lrg_pkg::t_cmd    o_cmd
);
    import lrg_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   w_in_take;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = (r_state == ST_WALK);
    assign w_in_take   = i_in_valid && o_in_ready;

    assign o_cmd.load  = w_in_take && (i_action == ACTION_DRAW);
    assign o_cmd.clear = w_in_take && (i_action == ACTION_CLEAR);
    assign o_cmd.step  = o_out_valid && i_out_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (o_cmd.load) n_state = ST_WALK;
            end
            ST_WALK: begin
                if (o_cmd.step && i_status.done) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end
endmodule

FILE: design/lrg_datapath.sv
module lrg_datapath (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  lrg_pkg::t_cmd          i_cmd,
    input  logic [lrg_pkg::XW-1:0] i_x_start,
    input  logic [lrg_pkg::YW-1:0] i_y_start,
    input  logic [lrg_pkg::XW-1:0] i_x_end,
    input  logic [lrg_pkg::YW-1:0] i_y_end,
    output lrg_pkg::t_status       o_status,
    output logic [lrg_pkg::XW-1:0] o_point_x,
    output logic [lrg_pkg::YW-1:0] o_point_y,
    output logic [1:0]             o_glyph,
    output logic                   o_write_cell
);
    import lrg_pkg::*;

    logic [XW-1:0]        r_cx, r_ex;
    logic [YW-1:0]        r_cy, r_ey;
    logic                 r_sx, r_sy;
    logic signed [EW-1:0] r_dx, r_dy, r_err;
    logic [GRID_WIDTH-1:0] r_rows [ROW_COUNT];

    logic signed [XW:0]   w_lx, w_ax;
    logic signed [YW:0]   w_ly, w_ay;
    logic signed [EW:0]   w_e2;
    logic                 w_mx, w_my;
    logic                 w_in_grid;
    logic [GRID_WIDTH-1:0] w_row;
    t_glyph               w_glyph;

    // Set-up values for a new line.
    assign w_lx = $signed({1'b0, i_x_end}) - $signed({1'b0, i_x_start});
    assign w_ly = $signed({1'b0, i_y_end}) - $signed({1'b0, i_y_start});
    assign w_ax = (w_lx < 0) ? -w_lx : w_lx;
    assign w_ay = (w_ly < 0) ? -w_ly : w_ly;

    // One Bresenham step.
    assign w_e2 = {r_err, 1'b0};
    assign w_mx = (w_e2 >= EW'(r_dy));
    assign w_my = (w_e2 <= EW'(r_dx));

    assign o_status.done = (r_cx == r_ex) && (r_cy == r_ey);

    always_comb begin
        if ((r_cx == r_ex) || (r_cy == r_ey))   w_glyph = GLYPH_DASH;
        else if ((r_ex > r_cx) == (r_ey > r_cy)) w_glyph = GLYPH_SLASH;
        else                                     w_glyph = GLYPH_BACKSLASH;
    end

    assign w_in_grid = ({1'b0, r_cx} < (XW+1)'(GRID_WIDTH)) &&
                       ({1'b0, r_cy} < (YW+1)'(GRID_HEIGHT));
    assign w_row     = r_rows[r_cy];

    assign o_point_x    = r_cx;
    assign o_point_y    = r_cy;
    assign o_glyph      = w_glyph;
    assign o_write_cell = w_in_grid && !w_row[r_cx];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cx  <= i_x_start;
            r_cy  <= i_y_start;
            r_ex  <= i_x_end;
            r_ey  <= i_y_end;
            r_sx  <= (i_x_start < i_x_end);
            r_sy  <= (i_y_start < i_y_end);
            r_dx  <= EW'(w_ax);
            r_dy  <= -EW'(w_ay);
            r_err <= EW'(w_ax) - EW'(w_ay);
        end else if (i_cmd.step) begin
            if (w_mx) r_cx <= r_sx ? r_cx + XW'(1) : r_cx - XW'(1);
            if (w_my) r_cy <= r_sy ? r_cy + YW'(1) : r_cy - YW'(1);
            r_err <= r_err + (w_mx ? r_dy : EW'(0)) + (w_my ? r_dx : EW'(0));
        end
    end

    // Occupancy bitmap: cleared by reset and by the clear action.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            for (int i = 0; i < ROW_COUNT; i++) r_rows[i] <= '0;
        end else if (i_cmd.step && o_write_cell) begin
            r_rows[r_cy][r_cx] <= 1'b1;
        end
    end
endmodule

FILE: tb/sv/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import lrg_pkg::*;

    // Every line fits within this many points, and the last one is marked.
    localparam int MAX_POINTS   = 64;
    // The largest number of cycles in which no transaction on either side is legal.
    // The long hold-off of the point side lasts HOLD_CYCLES, and random stalls are
    // far shorter than that, so this margin is generous.
    localparam int STALL_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 300;
    localparam int HOLD_TRIGGER = 1000;
    localparam int RANDOM_LINES = 100;

    // One request as the driver offers it.
    typedef struct packed {
        logic          action;
        logic [XW-1:0] x_start;
        logic [YW-1:0] y_start;
        logic [XW-1:0] x_end;
        logic [YW-1:0] y_end;
    } t_line_req;

    // One point as the block should hand it out.
    typedef struct packed {
        logic [XW-1:0] x;
        logic [YW-1:0] y;
        t_glyph        glyph;
        logic          write;
        logic          last;
    } t_plotted_point;

    logic i_clk;
    logic i_rst_n;

    lrg_in_if  req_if ();
    lrg_out_if pt_if ();

    line_rasterizer_with_glyphs dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_if),
        .o_out   (pt_if)
    );

    // Requests still to be offered, and the points the block owes us, oldest first.
    t_line_req      request_queue[$];
    t_plotted_point pending_points[$];

    // The testbench's own copy of the occupancy bitmap: bit x of row y set
    // means that cell has already been drawn since the last clear.
    logic [GRID_WIDTH-1:0] cell_taken[ROW_COUNT];

    t_line_req      offer;
    t_line_req      seen_req;
    t_line_req      last_drawn;
    t_plotted_point want;

    int unsigned send_gap_pct;
    int unsigned recv_gap_pct;
    int          fault_count;
    int          points_checked;
    int          idle_cycles;
    int          hold_left;
    bit          hold_done;
    bit          req_taken;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Walks the integer line exactly as the block should and queues one
    // expected point per step. A clear request empties the bitmap and
    // queues nothing; its endpoint fields play no part.
    function automatic void trace_line(t_line_req r);
        int cx, cy, ex, ey;
        int span_x, span_y, step_x, step_y, err, err2;
        int to_x, to_y, n;
        bit at_end;
        t_plotted_point p;
        if (r.action == ACTION_CLEAR) begin
            foreach (cell_taken[i]) cell_taken[i] = '0;
            return;
        end
        cx = int'(r.x_start);
        cy = int'(r.y_start);
        ex = int'(r.x_end);
        ey = int'(r.y_end);
        span_x = (ex > cx) ? ex - cx : cx - ex;
        span_y = (ey > cy) ? cy - ey : ey - cy;    // kept negative, as the walk expects
        step_x = (cx < ex) ? 1 : -1;
        step_y = (cy < ey) ? 1 : -1;
        err    = span_x + span_y;
        at_end = 1'b0;
        for (n = 0; n < MAX_POINTS && !at_end; n++) begin
            at_end  = (cx == ex) && (cy == ey);
            p.write = 1'b0;
            // Only cells inside the grid that are still empty get written.
            if (cx >= 0 && cx < GRID_WIDTH && cy >= 0 && cy < GRID_HEIGHT) begin
                if (!cell_taken[cy][cx]) begin
                    cell_taken[cy][cx] = 1'b1;
                    p.write = 1'b1;
                end
            end
            p.x = cx[XW-1:0];
            p.y = cy[YW-1:0];
            // The glyph follows the direction that is still left to the end point.
            to_x = ex - cx;
            to_y = ey - cy;
            if (to_x == 0 || to_y == 0) begin
                p.glyph = GLYPH_DASH;
            end else if ((to_x > 0) == (to_y > 0)) begin
                p.glyph = GLYPH_SLASH;
            end else begin
                p.glyph = GLYPH_BACKSLASH;
            end
            p.last = at_end || (n == MAX_POINTS - 1);
            pending_points.push_back(p);
            err2 = 2 * err;
            if (err2 >= span_y) begin
                err += span_y;
                cx  += step_x;
            end
            if (err2 <= span_x) begin
                err += span_x;
                cy  += step_y;
            end
        end
    endfunction

    function automatic void queue_line(logic act, int xs, int ys, int xe, int ye);
        t_line_req r;
        r.action  = act;
        r.x_start = xs[XW-1:0];
        r.y_start = ys[YW-1:0];
        r.x_end   = xe[XW-1:0];
        r.y_end   = ye[YW-1:0];
        request_queue.push_back(r);
    endfunction

    // Random requests: full-range lines as the largest share, with a share of short lines,
    // lines along one axis, repeats of the previous line (so that cells are
    // found occupied) and the odd clear with arbitrary endpoint fields.
    function automatic t_line_req random_request();
        t_line_req r;
        int pick, xe, ye;
        pick      = $urandom_range(99);
        r.action  = ACTION_DRAW;
        r.x_start = XW'($urandom_range(GRID_WIDTH - 1));
        r.y_start = YW'($urandom_range(GRID_HEIGHT - 1));
        r.x_end   = XW'($urandom_range(GRID_WIDTH - 1));
        r.y_end   = YW'($urandom_range(GRID_HEIGHT - 1));
        if (pick < 8) begin
            r.action = ACTION_CLEAR;
        end else if (pick < 22) begin
            r = last_drawn;
        end else if (pick < 40) begin
            xe = int'(r.x_start) + int'($urandom_range(6)) - 3;
            ye = int'(r.y_start) + int'($urandom_range(6)) - 3;
            if (xe < 0) xe = 0;
            if (xe > GRID_WIDTH - 1) xe = GRID_WIDTH - 1;
            if (ye < 0) ye = 0;
            if (ye > GRID_HEIGHT - 1) ye = GRID_HEIGHT - 1;
            r.x_end = xe[XW-1:0];
            r.y_end = ye[YW-1:0];
        end else if (pick < 48) begin
            r.y_end = r.y_start;
        end else if (pick < 56) begin
            r.x_end = r.x_start;
        end
        if (r.action == ACTION_DRAW) last_drawn = r;
        return r;
    endfunction

    function automatic void check_field(string label, logic [7:0] expected, logic [7:0] actual);
        if (actual !== expected) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, label, expected, actual);
            fault_count++;
        end
    endfunction

    // Waits until every request has been taken and every point has come back.
    // The test is made at rising edges, where the request queue and the request
    // bus are settled, and one more rising edge follows so that the caller may
    // refill the queue without meeting the driver at the same falling edge.
    task automatic drain();
        while (request_queue.size() != 0 || req_if.valid || pending_points.size() != 0) begin
            @(posedge i_clk);
        end
        @(posedge i_clk);
    endtask

    // Request driver. A new request is put on the bus at a falling edge once the
    // previous one has been taken as a transaction, or when the bus is empty.
    // The sender leaves a gap now and then, at the rate set for the phase.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else if (req_taken || !req_if.valid) begin
            if (request_queue.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                offer = request_queue.pop_front();
                req_if.action  <= offer.action;
                req_if.x_start <= offer.x_start;
                req_if.y_start <= offer.y_start;
                req_if.x_end   <= offer.x_end;
                req_if.y_end   <= offer.y_end;
                req_if.valid   <= 1'b1;
            end else begin
                req_if.valid <= 1'b0;
            end
        end
    end

    // Point receiver. It stalls at random at the rate of the phase, and once in
    // the run it holds off for a long stretch while the sender keeps offering,
    // so that the block must stop taking requests until it may move on.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            pt_if.ready <= 1'b0;
        end else if (hold_left > 0) begin
            pt_if.ready <= 1'b0;
            hold_left--;
        end else if (!hold_done && points_checked >= HOLD_TRIGGER) begin
            pt_if.ready <= 1'b0;
            hold_left = HOLD_CYCLES - 1;
            hold_done = 1'b1;
        end else begin
            pt_if.ready <= ($urandom_range(99) >= recv_gap_pct);
        end
    end

    // Monitor. At every rising edge it notes a request transaction and predicts
    // its points, then checks any point transaction against the oldest point
    // still owed. It also watches for the block going silent for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_taken   = 1'b0;
            idle_cycles = 0;
        end else begin
            req_taken = req_if.valid && req_if.ready;
            if (req_taken) begin
                seen_req = '{req_if.action, req_if.x_start, req_if.y_start,
                             req_if.x_end, req_if.y_end};
                trace_line(seen_req);
            end
            if (pt_if.valid && pt_if.ready) begin
                points_checked++;
                if (pending_points.size() == 0) begin
                    $display("%0t: point with none expected, actual x=%0d y=%0d glyph=%0d",
                             $time, pt_if.point_x, pt_if.point_y, pt_if.glyph);
                    fault_count++;
                end else begin
                    want = pending_points.pop_front();
                    check_field("point_x", 8'(want.x), 8'(pt_if.point_x));
                    check_field("point_y", 8'(want.y), 8'(pt_if.point_y));
                    check_field("glyph", 8'(want.glyph), 8'(pt_if.glyph));
                    check_field("write_cell", 8'(want.write), 8'(pt_if.write_cell));
                    check_field("last_point", 8'(want.last), 8'(pt_if.last_point));
                end
                idle_cycles = 0;
            end else if (req_taken) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= STALL_LIMIT) begin
                $display("%0t: no transaction for %0d cycles, %0d points still owed",
                         $time, idle_cycles, pending_points.size());
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n        = 1'b0;
        req_if.valid   = 1'b0;
        req_if.action  = ACTION_DRAW;
        req_if.x_start = '0;
        req_if.y_start = '0;
        req_if.x_end   = '0;
        req_if.y_end   = '0;
        pt_if.ready    = 1'b0;
        send_gap_pct   = 7;
        recv_gap_pct   = 69;
        fault_count    = 0;
        points_checked = 0;
        hold_left      = 0;
        hold_done      = 1'b0;
        foreach (cell_taken[i]) cell_taken[i] = '0;
        last_drawn     = '{ACTION_DRAW, 6'd0, 5'd0, 6'd63, 5'd31};

        // Directed lines, queued before reset is released. They cover single
        // point lines at both corners, full-length lines in every direction,
        // both diagonals, shallow and steep slopes, a line drawn twice so that
        // every cell is already taken, and a clear with non-zero endpoint
        // fields followed by the same line again.
        queue_line(ACTION_CLEAR, 0, 0, 0, 0);
        queue_line(ACTION_DRAW, 0, 0, 0, 0);
        queue_line(ACTION_DRAW, 63, 31, 63, 31);
        queue_line(ACTION_DRAW, 0, 0, 63, 0);
        queue_line(ACTION_DRAW, 63, 31, 0, 31);
        queue_line(ACTION_DRAW, 0, 0, 0, 31);
        queue_line(ACTION_DRAW, 63, 31, 63, 0);
        queue_line(ACTION_DRAW, 0, 0, 31, 31);
        queue_line(ACTION_DRAW, 0, 31, 31, 0);
        queue_line(ACTION_DRAW, 0, 0, 63, 31);
        queue_line(ACTION_DRAW, 63, 0, 0, 31);
        queue_line(ACTION_DRAW, 10, 5, 14, 30);
        queue_line(ACTION_DRAW, 50, 30, 45, 1);
        queue_line(ACTION_DRAW, 20, 10, 21, 11);
        queue_line(ACTION_DRAW, 0, 0, 63, 0);
        queue_line(ACTION_CLEAR, 63, 31, 63, 31);
        queue_line(ACTION_DRAW, 0, 0, 63, 0);
        queue_line(ACTION_DRAW, 40, 20, 8, 12);
        queue_line(ACTION_DRAW, 32, 16, 33, 16);
        queue_line(ACTION_DRAW, 5, 5, 4, 4);
        queue_line(ACTION_DRAW, 62, 1, 1, 30);
        repeat (RANDOM_LINES) request_queue.push_back(random_request());

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // First phase: the sender rarely pauses and the receiver often stalls.
        drain();

        // Second phase: the other way round.
        send_gap_pct = 69;
        recv_gap_pct = 7;
        repeat (RANDOM_LINES) request_queue.push_back(random_request());
        drain();

        // Last phase: both sides at full rate.
        send_gap_pct = 0;
        recv_gap_pct = 0;
        repeat (RANDOM_LINES) request_queue.push_back(random_request());
        drain();

        // A few more cycles catch any stray point after the last one owed.
        repeat (10) @(posedge i_clk);
        if (fault_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

FILE: sim.f
design/lrg_pkg.sv
design/lrg_in_if.sv
design/lrg_out_if.sv
design/lrg_ctrl.sv
design/lrg_datapath.sv
design/line_rasterizer_with_glyphs.sv
tb/sv/testbench.sv
